@@ design/lbm_pkg.sv @@
// ============================================================================
// lbm_pkg - shared types and constants for the lidar background mask
// Field widths, status codes, register indexes and the mask entry layout.
// ============================================================================
package lbm_pkg;

    localparam int unsigned BEAM_W       = 10;
    localparam int unsigned RANGE_W      = 16;
    localparam int unsigned STATUS_W     = 3;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned MAX_BEAMS    = 1 << BEAM_W;
    localparam int unsigned NUM_BEAMS_DEF = 1024;

    localparam logic [RANGE_W-1:0] RANGE_LOWER_RST    = '0;
    localparam logic [RANGE_W-1:0] RANGE_UPPER_RST    = '1;
    localparam logic [RANGE_W-1:0] BG_MARGIN_RST      = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_LOWER    = 2'd0,
        CFG_RANGE_UPPER    = 2'd1,
        CFG_BG_MARGIN      = 2'd2
    } cfg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INVALID    = 3'd0,
        STATUS_STORED     = 3'd1,
        STATUS_UNCHANGED  = 3'd2,
        STATUS_FOREGROUND = 3'd3,
        STATUS_BACKGROUND = 3'd4
    } status_t;

    // One mask word: presence flag above the stored range.
    typedef struct packed {
        logic               present;
        logic [RANGE_W-1:0] range;
    } mask_entry_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_lower;
        logic [RANGE_W-1:0] range_upper;
        logic [RANGE_W-1:0] bg_margin;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic        wr_en;
        mask_entry_t wr_entry;
    } verdict_t;

endpackage

@@ design/lidar_background_mask_unit.sv @@
// ============================================================================
// lidar_background_mask_unit - lidar background subtraction
// Learns the nearest range per beam and classifies test samples against it.
// ============================================================================
// An accepted word goes through the sample stage and then the output register to m_tvalid.
// Throughput: one word per cycle while m_tready stays high, set by a single read-modify-write
// of the mask memory per sample, with a one-entry bypass covering back-to-back hits.
// Reset: registers return to defaults, then a clearing pass writes all min(NUM_BEAMS,
// 1024) mask entries empty; s_tready stays low until it is done.
module lidar_background_mask_unit #(
    parameter int unsigned NUM_BEAMS = lbm_pkg::NUM_BEAMS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [lbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lbm_pkg::RANGE_W-1:0]    cfg_wdata,
    // Sample input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,  // [9:0] beam_index, [25:10] range
    input  logic [0:0]                     s_tuser,  // [0] action: 0 learn, 1 test
    // Result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,  // [9:0] beam_index_res, [25:10] range_res
    output logic [2:0]                     m_tuser   // [2:0] status
);

    // Only beam indexes that fit the input field can ever reach the mask.
    localparam int unsigned DEPTH = (NUM_BEAMS < lbm_pkg::MAX_BEAMS) ? NUM_BEAMS
                                                                     : lbm_pkg::MAX_BEAMS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned BW    = lbm_pkg::BEAM_W;
    localparam int unsigned RW    = lbm_pkg::RANGE_W;

    // ------------------------------------------------------------------
    // Configuration registers. The user must write only while the unit is idle (not enforced).
    // ------------------------------------------------------------------
    lbm_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_lower    <= lbm_pkg::RANGE_LOWER_RST;
            cfg_reg.range_upper    <= lbm_pkg::RANGE_UPPER_RST;
            cfg_reg.bg_margin      <= lbm_pkg::BG_MARGIN_RST;
        end else if (cfg_we) begin
            case (lbm_pkg::cfg_index_t'(cfg_index))
                lbm_pkg::CFG_RANGE_LOWER:    cfg_reg.range_lower    <= cfg_wdata;
                lbm_pkg::CFG_RANGE_UPPER:    cfg_reg.range_upper    <= cfg_wdata;
                lbm_pkg::CFG_BG_MARGIN:      cfg_reg.bg_margin      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Clearing pass after reset: one mask entry per cycle is written empty.
    // ------------------------------------------------------------------
    logic          clr_active_reg, clr_active_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    always_comb begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_active_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The sample stage advances whenever the output register
    // is empty or being drained, so a word can enter every cycle.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic m_valid_reg;
    logic s_accept;
    logic s1_advance;

    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready   = !clr_active_reg && (!s1_valid_reg || s1_advance);
    assign s_accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Sample stage: the input word is registered while the mask entry for
    // its beam is read from memory at the same edge.
    // ------------------------------------------------------------------
    logic          s1_action_reg;
    logic [BW-1:0] s1_beam_reg;
    logic [RW-1:0] s1_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_action_reg <= s_tuser[0];
            s1_beam_reg   <= s_tdata[BW-1:0];
            s1_range_reg  <= s_tdata[BW+RW-1:BW];
        end
    end

    // ------------------------------------------------------------------
    // Mask memory and write-back bypass. A write lands at the same edge as
    // the next sample's read, so the most recent write is kept aside and
    // used in place of the memory data when the beam matches.
    // ------------------------------------------------------------------
    lbm_pkg::mask_entry_t rd_entry;
    lbm_pkg::mask_entry_t cur_entry;
    lbm_pkg::mask_entry_t ram_wdata;
    lbm_pkg::verdict_t    verdict;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;

    logic                 byp_valid_reg;
    logic [AW-1:0]        byp_addr_reg;
    lbm_pkg::mask_entry_t byp_entry_reg;

    always_comb begin
        if (clr_active_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = s1_advance && verdict.wr_en;
            ram_waddr = s1_beam_reg[AW-1:0];
            ram_wdata = verdict.wr_entry;
        end
    end

    lbm_mask_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mask_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (s_tdata[AW-1:0]),
        .rdata (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else if (s1_advance && verdict.wr_en) begin
            byp_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && verdict.wr_en) begin
            byp_addr_reg  <= s1_beam_reg[AW-1:0];
            byp_entry_reg <= verdict.wr_entry;
        end
    end

    assign cur_entry = (byp_valid_reg && (byp_addr_reg == s1_beam_reg[AW-1:0]))
                     ? byp_entry_reg : rd_entry;

    lbm_classify #(
        .NUM_BEAMS (NUM_BEAMS)
    ) u_classify (
        .action     (s1_action_reg),
        .beam_index (s1_beam_reg),
        .range      (s1_range_reg),
        .entry      (cur_entry),
        .cfg        (cfg_reg),
        .verdict    (verdict)
    );

    // ------------------------------------------------------------------
    // Output register: holds the result word until the sink takes it.
    // ------------------------------------------------------------------
    logic [BW-1:0]    m_beam_reg;
    logic [RW-1:0]    m_range_reg;
    lbm_pkg::status_t m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_beam_reg   <= s1_beam_reg;
            m_range_reg  <= s1_range_reg;
            m_status_reg <= verdict.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_range_reg, m_beam_reg};
    assign m_tuser  = m_status_reg;

endmodule

@@ design/lbm_mask_ram.sv @@
// ============================================================================
// lbm_mask_ram - mask storage
// Simple dual-port memory: one write port, one read port with registered data.
// ============================================================================
module lbm_mask_ram #(
    parameter int unsigned DEPTH = lbm_pkg::NUM_BEAMS_DEF,
    parameter int unsigned AW    = 10
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  lbm_pkg::mask_entry_t wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output lbm_pkg::mask_entry_t rdata
);

    lbm_pkg::mask_entry_t mem [DEPTH];
    lbm_pkg::mask_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/lbm_classify.sv @@
// ============================================================================
// lbm_classify - per-sample decision
// Checks the range window and decides the status and the mask update.
// ============================================================================
module lbm_classify #(
    parameter int unsigned NUM_BEAMS = lbm_pkg::NUM_BEAMS_DEF
) (
    input  logic                         action,
    input  logic [lbm_pkg::BEAM_W-1:0]   beam_index,
    input  logic [lbm_pkg::RANGE_W-1:0]  range,
    input  lbm_pkg::mask_entry_t         entry,
    input  lbm_pkg::cfg_t                cfg,
    output lbm_pkg::verdict_t            verdict
);

    logic                         in_window;
    logic                         beam_ok;
    logic                         closer;
    logic                         background;
    logic [lbm_pkg::RANGE_W:0]    range_plus_thr;

    assign beam_ok   = {22'd0, beam_index} < 32'(NUM_BEAMS);
    assign in_window = (range > cfg.range_lower) && (range < cfg.range_upper) && beam_ok;
    assign closer    = entry.range > range;

    // entry - threshold < range, rearranged so nothing goes negative.
    assign range_plus_thr = {1'b0, range} + {1'b0, cfg.bg_margin};
    assign background     = entry.present && ({1'b0, entry.range} < range_plus_thr);

    always_comb begin
        verdict.status         = lbm_pkg::STATUS_INVALID;
        verdict.wr_en          = 1'b0;
        verdict.wr_entry.present = 1'b1;
        verdict.wr_entry.range = range;
        if (in_window) begin
            if (!action) begin
                if (!entry.present || closer) begin
                    verdict.status = lbm_pkg::STATUS_STORED;
                    verdict.wr_en  = 1'b1;
                end else begin
                    verdict.status = lbm_pkg::STATUS_UNCHANGED;
                end
            end else begin
                verdict.status = background ? lbm_pkg::STATUS_BACKGROUND
                                            : lbm_pkg::STATUS_FOREGROUND;
            end
        end
    end

endmodule
